/* rtl/core/m4vt_pkg.sv */
// Shared types and constants for the 4x4 matrix-vector transform unit.
`timescale 1ns / 1ps
`default_nettype none

package m4vt_pkg;

  localparam int DATA_W = 32;
  localparam int DIM    = 4;

  // Item opcodes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_POINT = 2'd1,
    CMD_DIR   = 2'd2,
    CMD_VEC   = 2'd3
  } cmd_t;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // Sideband that travels alongside the lane pipeline
  typedef struct packed {
    logic valid;
    cmd_t mode;
  } m4vt_tag_t;

  // One row result as seen by the merge stage
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     sat;
  } m4vt_lane_res_t;

endpackage

`default_nettype wire

/* rtl/core/m4vt_if.sv */
// Valid/ready channel interfaces for command items and transform results.
`timescale 1ns / 1ps
`default_nettype none

interface m4vt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [3:0]         entry_index;
  logic signed [31:0] entry_value;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [31:0] in_w;

  modport source (
    output valid, cmd, entry_index, entry_value, in_x, in_y, in_z, in_w,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, entry_value, in_x, in_y, in_z, in_w,
    output ready
  );
endinterface

interface m4vt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               overflow;

  modport source (
    output valid, out_x, out_y, out_z, out_w, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, overflow,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/m4vt_lane.sv */
// One matrix row lane: four multipliers, floor shift, adder tree, saturation.
`timescale 1ns / 1ps
`default_nettype none

module m4vt_lane
  import m4vt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [DIM-1:0][DATA_W-1:0]      row,
  input  wire logic [DIM-1:0][DATA_W-1:0]      vec,
  output m4vt_lane_res_t                       res
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int PAIR_W = SH_W + 1;
  localparam int SUM_W  = SH_W + 2;

  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [SH_W-1:0]   sh   [DIM];
  logic signed [PAIR_W-1:0] pair [2];
  logic signed [SUM_W-1:0]  total;
  logic                     sat;
  logic signed [DATA_W-1:0] clipped;

  // Stage 1: full-width products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIM; k++) begin
        prod[k] <= $signed(row[k]) * $signed(vec[k]);
      end
    end
  end

  // Floor shift drops the fraction bits; the result always fits SH_W
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      sh[k] = SH_W'(prod[k] >>> FRAC_BITS);
    end
  end

  // Stage 2: pairwise sums
  always_ff @(posedge clk) begin
    if (en) begin
      pair[0] <= {sh[0][SH_W-1], sh[0]} + {sh[1][SH_W-1], sh[1]};
      pair[1] <= {sh[2][SH_W-1], sh[2]} + {sh[3][SH_W-1], sh[3]};
    end
  end

  // Row total and clip to 32 bits: out of range when the upper bits disagree
  always_comb begin
    total   = {pair[0][PAIR_W-1], pair[0]} + {pair[1][PAIR_W-1], pair[1]};
    sat     = !((&total[SUM_W-1:DATA_W-1]) || !(|total[SUM_W-1:DATA_W-1]));
    clipped = sat ? (total[SUM_W-1] ? SAT_MIN : SAT_MAX) : total[DATA_W-1:0];
  end

  // Stage 3: registered row result
  always_ff @(posedge clk) begin
    if (en) begin
      res.value <= clipped;
      res.sat   <= sat;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/m4vt_merge.sv */
// Merge stage: combines the four row results into the output register.
`timescale 1ns / 1ps
`default_nettype none

module m4vt_merge
  import m4vt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire m4vt_tag_t             tag,
  input  wire m4vt_lane_res_t [DIM-1:0] res,
  output logic                       advance,
  m4vt_out_if.source                 rsp
);

  logic use_w;
  logic any_sat;

  // Pipeline moves whenever the output register is free or being drained
  assign advance = !rsp.valid || rsp.ready;

  // Row 3 counts only for full 4-vector transforms
  always_comb begin
    use_w   = (tag.mode == CMD_VEC);
    any_sat = res[0].sat || res[1].sat || res[2].sat || (use_w && res[3].sat);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= tag.valid;
    end
    if (advance) begin
      rsp.out_x    <= res[0].value;
      rsp.out_y    <= res[1].value;
      rsp.out_z    <= res[2].value;
      rsp.out_w    <= use_w ? res[3].value : '0;
      rsp.overflow <= any_sat;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/matrix4_vector_transform_unit.sv */
// Top level: matrix store, lane array and result merge of the transform unit.
`timescale 1ns / 1ps
`default_nettype none

// Affine 4x4 matrix-vector transform, signed fixed point with FRAC_BITS
// fraction bits (Q16.16 by default). The matrix resets to identity. A load
// item (cmd 0) writes one row-major entry in the cycle it is accepted and
// produces no result; the next item already sees the new value. Transform
// items (point, direction, full 4-vector) are accepted one per clock when
// the pipeline is not stalled. The datapath is four row lanes, each with
// four 32x32 multipliers, pipelined through product, pair-sum and
// saturation registers, then one output register.
// When the output is held by the sink the whole pipeline freezes and the
// input stops taking items until the output register drains.
module matrix4_vector_transform_unit
  import m4vt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  m4vt_in_if.sink    req,
  m4vt_out_if.source rsp
);

  localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam int STAGES = 3;

  logic [DIM*DIM-1:0][DATA_W-1:0] matrix;
  logic                           advance;
  logic                           accept;
  cmd_t                           cmd;
  logic signed [DATA_W-1:0]       w_term;
  logic [DIM-1:0][DATA_W-1:0]     vec;
  m4vt_tag_t                      tag_in;
  m4vt_tag_t                      tag [STAGES];
  m4vt_lane_res_t [DIM-1:0]       lane_res;

  assign req.ready = advance;
  assign accept    = req.valid && req.ready;
  assign cmd       = cmd_t'(req.cmd);

  // Fourth operand: w, the implied 1.0 for a point, or zero for a direction
  always_comb begin
    unique case (cmd)
      CMD_POINT: w_term = ONE;
      CMD_VEC:   w_term = req.in_w;
      default:   w_term = '0;
    endcase
    vec          = {w_term, req.in_z, req.in_y, req.in_x};
    tag_in.valid = accept && (cmd != CMD_LOAD);
    tag_in.mode  = cmd;
  end

  // Matrix store, identity at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          matrix[r*DIM+c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (accept && cmd == CMD_LOAD) begin
      matrix[req.entry_index] <= req.entry_value;
    end
  end

  // Sideband pipeline matching the lane depth
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        tag[s] <= '0;
      end
    end else if (advance) begin
      tag[0] <= tag_in;
      for (int s = 1; s < STAGES; s++) begin
        tag[s] <= tag[s-1];
      end
    end
  end

  // One lane per matrix row
  for (genvar r = 0; r < DIM; r++) begin : g_lane
    m4vt_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .en  (advance),
      .row (matrix[r*DIM +: DIM]),
      .vec (vec),
      .res (lane_res[r])
    );
  end

  m4vt_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .tag     (tag[STAGES-1]),
    .res     (lane_res),
    .advance (advance),
    .rsp     (rsp)
  );

  // A load lands in the addressed entry
  a_load_write: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_LOAD |=>
      matrix[$past(req.entry_index)] == $past(req.entry_value))
    else $error("matrix entry not written by load");

  // Identity right after reset
  a_reset_identity: assert property (@(posedge clk)
    rst |=> matrix[0] == ONE && matrix[5] == ONE &&
            matrix[10] == ONE && matrix[15] == ONE && matrix[1] == '0)
    else $error("matrix not identity after reset");

  // A transform reaching the end of the lanes becomes a result
  a_tail_to_out: assert property (@(posedge clk) disable iff (rst)
    advance && tag[STAGES-1].valid |=> rsp.valid)
    else $error("transform lost at merge stage");

  // Stalled pipeline keeps its sideband
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(tag[0]) && $stable(tag[STAGES-1]))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the 4x4 matrix-vector transform unit.
`timescale 1ns / 1ps

module testbench;
  import m4vt_pkg::*;

  localparam int FRAC_BITS     = 16;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int SQUEEZE_AT    = 900;
  localparam int SQUEEZE_ITEMS = 40;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 12;
  localparam int IDLE_LIMIT    = 4000;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    cmd_t               cmd;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } xform_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               ovf;
  } xform_result_t;

  typedef struct {
    xform_item_t   item;
    bit            typed;
    xform_result_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  m4vt_in_if  req_ch ();
  m4vt_out_if rsp_ch ();

  matrix4_vector_transform_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: matrix copy and expected outputs in order
  logic signed [31:0] coeff [16];
  xform_result_t      pending_results [$];
  int                 mismatch_count = 0;
  bit                 tx_burst = 1'b0;
  bit                 rx_burst = 1'b0;
  bit                 squeeze_req = 1'b0;

  function automatic xform_item_t make_item(cmd_t cmd, logic [3:0] idx,
                                            logic signed [31:0] val,
                                            logic signed [31:0] x,
                                            logic signed [31:0] y,
                                            logic signed [31:0] z,
                                            logic signed [31:0] w);
    xform_item_t it;
    it.cmd = cmd;
    it.idx = idx;
    it.val = val;
    it.x   = x;
    it.y   = y;
    it.z   = z;
    it.w   = w;
    return it;
  endfunction

  function automatic xform_result_t make_result(logic signed [31:0] x,
                                                logic signed [31:0] y,
                                                logic signed [31:0] z,
                                                logic signed [31:0] w,
                                                logic ovf);
    xform_result_t r;
    r.x   = x;
    r.y   = y;
    r.z   = z;
    r.w   = w;
    r.ovf = ovf;
    return r;
  endfunction

  // Full-width product, floor shift by the fraction bits
  function automatic logic signed [63:0] scaled_product(logic signed [31:0] a,
                                                        logic signed [31:0] b);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    wa = a;
    wb = b;
    return (wa * wb) >>> FRAC_BITS;
  endfunction

  // Row sums with translation per mode, saturated to 32 bits
  function automatic xform_result_t transform_vector(xform_item_t it);
    logic signed [31:0] vin  [4];
    logic signed [31:0] lane [4];
    logic signed [63:0] acc;
    logic               ovf;
    vin[0] = it.x;
    vin[1] = it.y;
    vin[2] = it.z;
    vin[3] = it.w;
    ovf    = 1'b0;
    for (int r = 0; r < 4; r++) begin
      lane[r] = '0;
      if (r < 3 || it.cmd == CMD_VEC) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          acc = acc + scaled_product(coeff[r*4+k], vin[k]);
        end
        if (it.cmd == CMD_POINT) begin
          acc = acc + coeff[r*4+3];
        end else if (it.cmd == CMD_VEC) begin
          acc = acc + scaled_product(coeff[r*4+3], vin[3]);
        end
        if (acc > SAT_MAX) begin
          lane[r] = SAT_MAX;
          ovf     = 1'b1;
        end else if (acc < SAT_MIN) begin
          lane[r] = SAT_MIN;
          ovf     = 1'b1;
        end else begin
          lane[r] = acc[31:0];
        end
      end
    end
    return make_result(lane[0], lane[1], lane[2], lane[3], ovf);
  endfunction

  // Mix of full-range, small fractional, whole and extreme Q16.16 values
  function automatic logic signed [31:0] draw_q16();
    logic signed [31:0] q;
    case ($urandom_range(0, 5))
      0, 1: q = $urandom();
      2, 3: q = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      4: begin
        case ($urandom_range(0, 4))
          0:       q = SAT_MAX;
          1:       q = SAT_MIN;
          2:       q = '0;
          3:       q = Q_ONE;
          default: q = -Q_ONE;
        endcase
      end
      default: q = ($signed($urandom_range(0, 16)) - 8) <<< FRAC_BITS;
    endcase
    return q;
  endfunction

  // Drive one item, wait for its transfer, then update the predictor
  task automatic send_item(input xform_item_t it, input bit typed,
                           input xform_result_t typed_res, input bit no_gap);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = (no_gap || tx_burst) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= it.cmd;
    req_ch.entry_index <= it.idx;
    req_ch.entry_value <= it.val;
    req_ch.in_x        <= it.x;
    req_ch.in_y        <= it.y;
    req_ch.in_z        <= it.z;
    req_ch.in_w        <= it.w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (it.cmd == CMD_LOAD) begin
      coeff[it.idx] = it.val;
    end else if (typed) begin
      pending_results.push_back(typed_res);
    end else begin
      pending_results.push_back(transform_vector(it));
    end
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Result side: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    xform_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: expected none, actual %h %h %h %h %b", $time,
                 rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.out_w, rsp_ch.overflow);
      end else begin
        want = pending_results.pop_front();
        check_field("out_x", want.x, rsp_ch.out_x);
        check_field("out_y", want.y, rsp_ch.out_y);
        check_field("out_z", want.z, rsp_ch.out_z);
        check_field("out_w", want.w, rsp_ch.out_w);
        check_field("overflow", {31'd0, want.ovf}, {31'd0, rsp_ch.overflow});
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    int idle_cycles;
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls per result, one long hold-off on request
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Sender: directed table, then random stream
  initial begin
    directed_row_t plan [$];
    xform_item_t   it;
    cmd_t          pick;

    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_LOAD;
    req_ch.entry_index <= '0;
    req_ch.entry_value <= '0;
    req_ch.in_x        <= '0;
    req_ch.in_y        <= '0;
    req_ch.in_z        <= '0;
    req_ch.in_w        <= '0;

    for (int i = 0; i < 16; i++) coeff[i] = (i % 5 == 0) ? Q_ONE : '0;

    // identity after reset, in every mode; ignored fields hold junk
    plan.push_back('{make_item(CMD_POINT, 4'hF, 32'shDEAD_BEEF, Q_ONE, 32'shFFFE_0000,
                               32'sh0003_8000, 32'sh5A5A_5A5A), 1'b1,
                     make_result(Q_ONE, 32'shFFFE_0000, 32'sh0003_8000, '0, 1'b0)});
    plan.push_back('{make_item(CMD_DIR, 4'h0, 32'sh1234_5678, Q_ONE, 32'shFFFE_0000,
                               32'sh0003_8000, SAT_MIN), 1'b1,
                     make_result(Q_ONE, 32'shFFFE_0000, 32'sh0003_8000, '0, 1'b0)});
    plan.push_back('{make_item(CMD_VEC, 4'h5, '0, SAT_MIN, SAT_MAX, '0, -32'sd1), 1'b1,
                     make_result(SAT_MIN, SAT_MAX, '0, -32'sd1, 1'b0)});
    // translation column: +10.0, -5.0, max
    plan.push_back('{make_item(CMD_LOAD, 4'd3, 32'sh000A_0000, 32'sh7777_7777, '1, '1, '1),
                     1'b0, '0});
    plan.push_back('{make_item(CMD_LOAD, 4'd7, 32'shFFFB_0000, '0, '0, '0, '0), 1'b0, '0});
    plan.push_back('{make_item(CMD_LOAD, 4'd11, SAT_MAX, '0, '0, '0, '0), 1'b0, '0});
    // point adds translation and saturates z; direction does not
    plan.push_back('{make_item(CMD_POINT, 4'd0, '0, Q_ONE, Q_ONE, Q_ONE, 32'sh0BAD_0BAD), 1'b1,
                     make_result(32'sh000B_0000, 32'shFFFC_0000, SAT_MAX, '0, 1'b1)});
    plan.push_back('{make_item(CMD_DIR, 4'd0, '0, Q_ONE, Q_ONE, Q_ONE, SAT_MAX), 1'b1,
                     make_result(Q_ONE, Q_ONE, Q_ONE, '0, 1'b0)});
    plan.push_back('{make_item(CMD_VEC, 4'd0, '0, '0, '0, '0, Q_ONE), 1'b1,
                     make_result(32'sh000A_0000, 32'shFFFB_0000, SAT_MAX, Q_ONE, 1'b0)});
    // extreme products saturate both ways
    plan.push_back('{make_item(CMD_LOAD, 4'd0, SAT_MAX, '0, '0, '0, '0), 1'b0, '0});
    plan.push_back('{make_item(CMD_DIR, 4'd0, '0, SAT_MAX, '0, '0, '0), 1'b1,
                     make_result(SAT_MAX, '0, '0, '0, 1'b1)});
    plan.push_back('{make_item(CMD_DIR, 4'd0, '0, SAT_MIN, '0, '0, '0), 1'b1,
                     make_result(SAT_MIN, '0, '0, '0, 1'b1)});
    plan.push_back('{make_item(CMD_LOAD, 4'd0, SAT_MIN, '0, '0, '0, '0), 1'b0, '0});
    plan.push_back('{make_item(CMD_DIR, 4'd0, '0, SAT_MIN, '0, '0, '0), 1'b1,
                     make_result(SAT_MAX, '0, '0, '0, 1'b1)});
    // shift rounds toward minus infinity
    plan.push_back('{make_item(CMD_LOAD, 4'd0, 32'sd1, '0, '0, '0, '0), 1'b0, '0});
    plan.push_back('{make_item(CMD_DIR, 4'd0, '0, -32'sd1, '0, '0, '0), 1'b1,
                     make_result(-32'sd1, '0, '0, '0, 1'b0)});
    // w input at the negative extreme, all four lanes saturate
    plan.push_back('{make_item(CMD_LOAD, 4'd15, 32'shFFFE_0000, '0, '0, '0, '0), 1'b0, '0});
    plan.push_back('{make_item(CMD_VEC, 4'd0, '0, '0, '0, '0, SAT_MIN), 1'b1,
                     make_result(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, 1'b1)});
    // mixed values, checked by the predictor
    plan.push_back('{make_item(CMD_POINT, 4'd9, '0, 32'sh1234_5678, 32'shEDCB_A988,
                               32'sh0000_8001, '0), 1'b0, '0});
    plan.push_back('{make_item(CMD_LOAD, 4'd5, 32'sh0000_C000, '0, '0, '0, '0), 1'b0, '0});
    plan.push_back('{make_item(CMD_LOAD, 4'd6, 32'shFFFF_4000, '0, '0, '0, '0), 1'b0, '0});
    plan.push_back('{make_item(CMD_VEC, 4'd0, '0, 32'sh0003_0000, 32'shFFFD_8000,
                               32'sh7FFF_0000, 32'sd1), 1'b0, '0});
    plan.push_back('{make_item(CMD_POINT, 4'd0, '0, -32'sd1, -32'sd1, -32'sd1, '0), 1'b0, '0});
    plan.push_back('{make_item(CMD_DIR, 4'd0, '0, 32'sh8000_0001, 32'sh7FFF_FFFE,
                               32'shFFFF_8000, '0), 1'b0, '0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].res, 1'b0);

    // Random stream: loads keep reshaping the matrix between transforms
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 7))
        0, 1:    pick = CMD_LOAD;
        2, 3:    pick = CMD_POINT;
        4, 5:    pick = CMD_DIR;
        default: pick = CMD_VEC;
      endcase
      it = make_item(pick, 4'($urandom_range(0, 15)), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom());
      if (pick == CMD_LOAD) begin
        it.val = draw_q16();
      end else begin
        it.x = draw_q16();
        it.y = draw_q16();
        it.z = draw_q16();
        it.w = draw_q16();
      end
      if (n == SQUEEZE_AT) squeeze_req = 1'b1;
      send_item(it, 1'b0, '0,
                (n >= SQUEEZE_AT) && (n < SQUEEZE_AT + SQUEEZE_ITEMS));
    end
    req_ch.valid <= 1'b0;

    // Drain, then allow stray results to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/m4vt_pkg.sv
rtl/core/m4vt_if.sv
rtl/core/m4vt_lane.sv
rtl/core/m4vt_merge.sv
rtl/core/matrix4_vector_transform_unit.sv
tb/sv/testbench.sv
